/* src/wmse_pkg.sv */
// ----------------------------------------------------------------------------
// wmse_pkg
// Shared types and codes of the weighted mean / standard error block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmse_pkg;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SINGLE   = 2'd1,
    STAT_ZERO_WT  = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic accumulate;
    logic mean_start;
    logic mean_latch;
    logic pass_init;
    logic rd;
    logic ratio_start;
    logic mul1;
    logic mul2;
    logic sum;
    logic var_start;
    logic var_add;
    logic sqrt_start;
    logic out_load;
  } wmse_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;
    logic wt_zero;
    logic multi;
    logic div_busy;
    logic sqrt_busy;
    logic pass_end;
    logic out_free;
  } wmse_stat_t;

endpackage

`default_nettype wire

/* src/wmse_sample_if.sv */
// ----------------------------------------------------------------------------
// wmse_sample_if
// Input channel: one weighted sample per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmse_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic        [31:0] sample_weight;
  logic               last_item;

  modport source (output valid, sample_value, sample_weight, last_item, input ready);
  modport sink   (input valid, sample_value, sample_weight, last_item, output ready);
endinterface

`default_nettype wire

/* src/wmse_result_if.sv */
// ----------------------------------------------------------------------------
// wmse_result_if
// Output channel: mean, standard error, sample count and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmse_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] weighted_mean;
  logic        [31:0] standard_error;
  logic        [8:0]  samples_used;
  logic        [1:0]  status;

  modport source (output valid, weighted_mean, standard_error, samples_used, status,
                  input ready);
  modport sink   (input valid, weighted_mean, standard_error, samples_used, status,
                  output ready);
endinterface

`default_nettype wire

/* src/wmse_div.sv */
// ----------------------------------------------------------------------------
// wmse_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module wmse_div #(
  parameter int unsigned DVW = 82,
  parameter int unsigned DSW = 41
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [DVW-1:0] dividend_i,
  input  wire logic [DSW-1:0] divisor_i,
  output logic                busy_o,
  output logic [DVW-1:0]      quotient_o
);

  localparam int unsigned CW = $clog2(DVW);

  logic           busy_q;
  logic [CW-1:0]  cnt_q;
  logic [DVW-1:0] quo_q;
  logic [DSW-1:0] rem_q;
  logic [DSW-1:0] dsr_q;
  logic [DSW:0]   shifted;
  logic           ge;
  logic [DSW:0]   diff;

  // one restoring step
  always_comb begin
    shifted = {rem_q, quo_q[DVW-1]};
    ge      = shifted >= {1'b0, dsr_q};
    diff    = shifted - {1'b0, dsr_q};
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DVW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DSW-1:0] : shifted[DSW-1:0];
      quo_q <= {quo_q[DVW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* src/wmse_sqrt.sv */
// ----------------------------------------------------------------------------
// wmse_sqrt
// Integer square root, one root bit per cycle (two radicand bits a step).
// ----------------------------------------------------------------------------
`default_nettype none

module wmse_sqrt #(
  parameter int unsigned SQW = 76
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [SQW-1:0] radicand_i,
  output logic                busy_o,
  output logic [SQW/2-1:0]    root_o
);

  localparam int unsigned HW = SQW / 2;
  localparam int unsigned CW = $clog2(HW);

  logic           busy_q;
  logic [CW-1:0]  cnt_q;
  logic [SQW-1:0] rad_q;
  logic [HW-1:0]  root_q;
  logic [HW+1:0]  rem_q;
  logic [HW+1:0]  trial_rem;
  logic [HW+1:0]  trial;
  logic           ge;

  // one digit step
  always_comb begin
    trial_rem = {rem_q[HW-1:0], rad_q[SQW-1:SQW-2]};
    trial     = {root_q, 2'b01};
    ge        = trial_rem >= trial;
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(HW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // root and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SQW-3:0], 2'b00};
      rem_q  <= ge ? (trial_rem - trial) : trial_rem;
      root_q <= {root_q[HW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

/* src/wmse_datapath.sv */
// ----------------------------------------------------------------------------
// wmse_datapath
// Sample stores, running sums, second pass arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wmse_datapath #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire wmse_pkg::wmse_cmd_t cmd_i,
  output wmse_pkg::wmse_stat_t    stat_o,
  input  wire logic signed [31:0] sample_value_i,
  input  wire logic        [31:0] sample_weight_i,
  input  wire logic               last_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      weighted_mean_o,
  output logic        [31:0]      standard_error_o,
  output logic        [8:0]       samples_used_o,
  output logic        [1:0]       status_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam int unsigned WTW  = 32 + CNTW;
  localparam int unsigned ACCW = 66 + CNTW;
  localparam int unsigned DVW  = (64 + FRAC_BITS > ACCW) ? 64 + FRAC_BITS : ACCW;
  localparam int unsigned VARW = ACCW + 1;
  localparam int unsigned SQW  = VARW + (VARW % 2);
  localparam int unsigned HW   = SQW / 2;

  // sample stores
  logic [31:0] value_mem  [DEPTH];
  logic [31:0] weight_mem [DEPTH];

  logic [CNTW-1:0]    count_q;
  logic               ovf_q;
  logic [63:0]        ps_q;
  logic [WTW-1:0]     wt_q;
  logic signed [63:0] prod_q;
  logic [31:0]        w_in_q;
  logic               store_q;
  logic               last_q;
  logic [31:0]        mean_q;
  logic [CNTW-1:0]    idx_q;
  logic [31:0]        rdx_q;
  logic [31:0]        rdw_q;
  logic [32:0]        ad_q;
  logic [64:0]        mprod_q;
  logic [65:0]        tsq_q;
  logic [ACCW-1:0]    acc_q;
  logic [SQW-1:0]     var_q;
  logic               out_valid_q;

  logic               store_ok;
  logic signed [64:0] prod_full;
  logic [63:0]        mag;
  logic [DVW-1:0]     div_dvd;
  logic [WTW-1:0]     div_dsr;
  logic               div_start;
  logic               div_busy;
  logic [DVW-1:0]     quo;
  logic               sqrt_busy;
  logic [HW-1:0]      root;
  logic               pos_ovf;
  logic               neg_ovf;
  logic [31:0]        mean_d;
  logic [33:0]        diff;
  logic [33:0]        diff_neg;
  logic [32:0]        ad_d;
  logic [64:0]        mprod_d;
  logic [32:0]        t_val;
  logic [65:0]        tsq_d;
  logic [CNTW+8:0]    n_wide;
  logic               wt_zero;
  logic               multi;

  // input product and store check
  always_comb begin
    store_ok  = count_q < CNTW'(DEPTH);
    prod_full = $signed({1'b0, sample_weight_i}) * $signed({sample_value_i[31], sample_value_i});
  end

  // sample stores, written in arrival order
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && store_ok) begin
      value_mem[count_q[AW-1:0]]  <= sample_value_i;
      weight_mem[count_q[AW-1:0]] <= sample_weight_i;
    end
    if (cmd_i.rd) begin
      rdx_q <= value_mem[idx_q[AW-1:0]];
      rdw_q <= weight_mem[idx_q[AW-1:0]];
    end
  end

  // running sums and set bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      ps_q    <= '0;
      wt_q    <= '0;
      store_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        store_q <= store_ok;
        last_q  <= last_item_i;
      end
      if (cmd_i.accumulate) begin
        if (store_q) begin
          count_q <= count_q + 1'b1;
          wt_q    <= wt_q + WTW'(w_in_q);
          ps_q    <= ps_q + 64'(prod_q >>> FRAC_BITS);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        ps_q    <= '0;
        wt_q    <= '0;
      end
    end
  end

  // shared divider operand selection
  always_comb begin
    mag       = ps_q[63] ? (~ps_q + 64'd1) : ps_q;
    div_start = cmd_i.mean_start | cmd_i.ratio_start | cmd_i.var_start;
    if (cmd_i.mean_start) begin
      div_dvd = DVW'(mag) << FRAC_BITS;
    end else if (cmd_i.ratio_start) begin
      div_dvd = DVW'({rdw_q, 31'b0});
    end else begin
      div_dvd = DVW'(acc_q);
    end
    div_dsr = cmd_i.var_start ? WTW'(count_q - 1'b1) : wt_q;
  end

  wmse_div #(
    .DVW (DVW),
    .DSW (WTW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  wmse_sqrt #(
    .SQW (SQW)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (var_q),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  // saturated mean, deviation and products
  always_comb begin
    pos_ovf = |quo[DVW-1:31];
    neg_ovf = (|quo[DVW-1:32]) | (quo[31] & (|quo[30:0]));
    if (ps_q[63]) begin
      mean_d = neg_ovf ? 32'h8000_0000 : (~quo[31:0] + 32'd1);
    end else begin
      mean_d = pos_ovf ? 32'h7FFF_FFFF : quo[31:0];
    end
    diff     = {{2{rdx_q[31]}}, rdx_q} - {{2{mean_q[31]}}, mean_q};
    diff_neg = ~diff + 34'd1;
    ad_d     = diff[33] ? diff_neg[32:0] : diff[32:0];
    mprod_d  = 65'(ad_q) * 65'(quo[31:0]);
    t_val    = mprod_q[63:31];
    tsq_d    = 66'(t_val) * 66'(t_val);
  end

  // second pass registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prod_q <= prod_full[63:0];
      w_in_q <= sample_weight_i;
    end
    if (cmd_i.mean_latch) begin
      mean_q <= mean_d;
    end
    if (cmd_i.ratio_start) begin
      ad_q <= ad_d;
    end
    if (cmd_i.mul1) begin
      mprod_q <= mprod_d;
    end
    if (cmd_i.mul2) begin
      tsq_q <= tsq_d;
    end
    if (cmd_i.var_add) begin
      var_q <= SQW'(acc_q) + SQW'(quo[ACCW-1:0]);
    end
  end

  // pass index and square sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      acc_q <= '0;
    end else if (cmd_i.pass_init) begin
      idx_q <= '0;
      acc_q <= '0;
    end else if (cmd_i.sum) begin
      idx_q <= idx_q + 1'b1;
      acc_q <= acc_q + ACCW'(tsq_q);
    end
  end

  // result register
  always_comb begin
    wt_zero = wt_q == '0;
    multi   = count_q >= CNTW'(2);
    n_wide  = (CNTW + 9)'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      weighted_mean_o  <= wt_zero ? 32'sd0 : $signed(mean_q);
      if (wt_zero || !multi) begin
        standard_error_o <= '0;
      end else begin
        standard_error_o <= (|root[HW-1:32]) ? 32'hFFFF_FFFF : root[31:0];
      end
      samples_used_o <= (n_wide > (CNTW + 9)'(511)) ? 9'd511 : n_wide[8:0];
      if (wt_zero) begin
        status_o <= wmse_pkg::STAT_ZERO_WT;
      end else if (ovf_q) begin
        status_o <= wmse_pkg::STAT_OVERFLOW;
      end else if (!multi) begin
        status_o <= wmse_pkg::STAT_SINGLE;
      end else begin
        status_o <= wmse_pkg::STAT_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // status to the controller
  always_comb begin
    stat_o.last      = last_q;
    stat_o.wt_zero   = wt_zero;
    stat_o.multi     = multi;
    stat_o.div_busy  = div_busy;
    stat_o.sqrt_busy = sqrt_busy;
    stat_o.pass_end  = idx_q == (count_q - 1'b1);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

/* src/wmse_ctrl.sv */
// ----------------------------------------------------------------------------
// wmse_ctrl
// Sequencer for sample loading, mean division, second pass, variance division, root and output.
// ----------------------------------------------------------------------------
`default_nettype none

module wmse_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire wmse_pkg::wmse_stat_t stat_i,
  output wmse_pkg::wmse_cmd_t      cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_ACC  = 15'b000000000000010,
    S_CHK  = 15'b000000000000100,
    S_MDIV = 15'b000000000001000,
    S_RD   = 15'b000000000010000,
    S_RW   = 15'b000000000100000,
    S_RDIV = 15'b000000001000000,
    S_MUL1 = 15'b000000010000000,
    S_MUL2 = 15'b000000100000000,
    S_SUM  = 15'b000001000000000,
    S_VDIV = 15'b000010000000000,
    S_VDW  = 15'b000100000000000,
    S_SQS  = 15'b001000000000000,
    S_SQW  = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.accumulate = 1'b1;
        state_d          = stat_i.last ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        if (stat_i.wt_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.mean_start = 1'b1;
          state_d          = S_MDIV;
        end
      end
      S_MDIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.mean_latch = 1'b1;
          cmd_o.pass_init  = 1'b1;
          state_d          = stat_i.multi ? S_RD : S_OUT;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_RW;
      end
      S_RW: begin
        cmd_o.ratio_start = 1'b1;
        state_d           = S_RDIV;
      end
      S_RDIV: begin
        if (!stat_i.div_busy) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = stat_i.pass_end ? S_VDIV : S_RD;
      end
      S_VDIV: begin
        cmd_o.var_start = 1'b1;
        state_d         = S_VDW;
      end
      S_VDW: begin
        if (!stat_i.div_busy) begin
          cmd_o.var_add = 1'b1;
          state_d       = S_SQS;
        end
      end
      S_SQS: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQW;
      end
      S_SQW: begin
        if (!stat_i.sqrt_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* src/weighted_mean_std_error.sv */
// Samples load one at a time in two steps (store write and product, then sum update).
// A last item with n >= 2 stored samples then runs the mean division, per sample a read, a ratio
// division, two multiplies and a sum, then the variance division and the root, and waits for a free
// output; the divisions share one bit-serial divider (mean, ratios, variance).
// Async active-low reset clears the controller, sums, count and result valid;
// the sample stores are not cleared and are only read where written.
// ----------------------------------------------------------------------------
// weighted_mean_std_error
// Weighted mean and standard error sqrt(n/(n-1) * sum((w/W)^2 * (x - mean)^2)) over weighted samples.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_mean_std_error #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  wmse_sample_if.sink   sample_i,
  wmse_result_if.source result_o
);

  wmse_pkg::wmse_cmd_t  cmd;
  wmse_pkg::wmse_stat_t stat;

  wmse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wmse_datapath #(
    .DEPTH     (DEPTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .sample_value_i   (sample_i.sample_value),
    .sample_weight_i  (sample_i.sample_weight),
    .last_item_i      (sample_i.last_item),
    .out_valid_o      (result_o.valid),
    .out_ready_i      (result_o.ready),
    .weighted_mean_o  (result_o.weighted_mean),
    .standard_error_o (result_o.standard_error),
    .samples_used_o   (result_o.samples_used),
    .status_o         (result_o.status)
  );

endmodule

`default_nettype wire

/* src/wmse_checker.sv */
// ----------------------------------------------------------------------------
// wmse_checker
// Port-level checks of the weighted mean block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wmse_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] mean_i,
  input wire logic [31:0] se_i,
  input wire logic [8:0]  used_i,
  input wire logic [1:0]  status_i
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its mean, error and status
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(mean_i) && $stable(se_i) && $stable(status_i))
    else $error("result payload changed while stalled");

  // ready is low right after every accepted item
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted in back-to-back cycles");

  // zero weight sum gives zero mean and error
  a_zero_wt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == wmse_pkg::STAT_ZERO_WT |-> mean_i == '0 && se_i == '0)
    else $error("zero weight result not cleared");

  // a single sample result has one sample used and zero error
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == wmse_pkg::STAT_SINGLE |-> used_i == 9'd1 && se_i == '0)
    else $error("single sample result inconsistent");

endmodule

bind weighted_mean_std_error wmse_checker u_wmse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .mean_i      (result_o.weighted_mean),
  .se_i        (result_o.standard_error),
  .used_i      (result_o.samples_used),
  .status_i    (result_o.status)
);

`default_nettype wire
